// ===== rtl/core/assert_macros.svh =====
// ---------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands: clocked on clk, disabled while arst_n is low.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising edge outside reset.
`define AFS_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Antecedent leads to consequent in the following cycle.
`define AFS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/afs_pkg.sv =====
// ---------------------------------------------------------------------------
// afs_pkg
// Shared types and constants of the animation frame selector.
// ---------------------------------------------------------------------------
package afs_pkg;

	localparam int FRAME_DEPTH = 256;
	localparam int ANIM_DEPTH  = 64;
	localparam int FRAME_AW    = $clog2(FRAME_DEPTH);
	localparam int ANIM_AW     = $clog2(ANIM_DEPTH);
	localparam int TOTAL_W     = 40;
	localparam int QUO_W       = 64;

	localparam logic [1:0] FN_WR_FRAME = 2'd0;
	localparam logic [1:0] FN_WR_ANIM  = 2'd1;
	localparam logic [1:0] FN_QUERY    = 2'd2;

	localparam logic [7:0] CFG_SPRITE_COUNT = 8'd0;
	localparam logic [7:0] CFG_ANIM_COUNT   = 8'd1;

	typedef struct packed {
		logic [1:0]  func;
		logic [7:0]  entry_index;
		logic [15:0] sprite_num;
		logic [31:0] frame_time;
		logic [7:0]  first_frame;
		logic [8:0]  num_frames;
		logic [31:0] loop_limit;
		logic [5:0]  anim_sel;
		logic [63:0] run_time;
	} req_t;

	typedef struct packed {
		logic [15:0] frame_sprite;
		logic        finished;
		logic        error;
	} rsp_t;

	typedef struct packed {
		logic [15:0] sprite;
		logic [31:0] duration;
	} frame_ent_t;

	typedef struct packed {
		logic [7:0]  first;
		logic [8:0]  length;
		logic [31:0] repeats;
	} anim_ent_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_ALOOK,
		S_SUM,
		S_DIV,
		S_CHK,
		S_WALK
	} state_t;

endpackage

// ===== rtl/core/afs_ram.sv =====
// ---------------------------------------------------------------------------
// afs_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module afs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ===== rtl/core/animation_frame_select.sv =====
// ---------------------------------------------------------------------------
// animation_frame_select
// Sprite animation frame selector: frame and animation tables plus query.
// ---------------------------------------------------------------------------
// Write requests finish in the cycle they are taken and keep busy low. A
// query runs animation lookup, a duration sum over its N frames, a 64-step
// restoring divider for elapsed / total, a loop check and a walk to the hit
// frame, with one frame-table read per cycle in the sum and the walk. Invalid
// queries end in the lookup or sum state. The result appears for one cycle
// with done high; the receiver cannot stall it. Frame entries read as zero
// until written; unwritten animations give an error (valid flops per entry).
`include "assert_macros.svh"

module animation_frame_select (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  afs_pkg::req_t req,
	output logic          done,
	output afs_pkg::rsp_t rsp,
	input  logic          cfg_valid,
	output logic          cfg_ready,
	input  logic [7:0]    cfg_index,
	input  logic [15:0]   cfg_data
);
	import afs_pkg::*;

	state_t state_q, state_d;

	logic [15:0] sprite_count_q;
	logic [6:0]  anim_count_q;

	logic [FRAME_DEPTH-1:0] fvalid_q;
	logic [ANIM_DEPTH-1:0]  avalid_q;
	logic                   fval_s1, aval_s1;

	logic                f_we, a_we;
	logic [FRAME_AW-1:0] f_raddr;
	logic [ANIM_AW-1:0]  a_raddr, a_waddr;
	logic [$bits(frame_ent_t)-1:0] f_rdata;
	logic [$bits(anim_ent_t)-1:0]  a_rdata;
	frame_ent_t          f_wr, f_rd;
	anim_ent_t           a_wr, a_rd;

	logic                id_bad_q;
	logic [7:0]          first_q;
	logic [8:0]          len_q;
	logic [31:0]         rep_q;
	logic [FRAME_AW-1:0] ptr_q;
	logic [8:0]          idx_q;
	logic [TOTAL_W-1:0]  total_q;
	logic [TOTAL_W-1:0]  rem_q;
	logic [QUO_W-1:0]    quo_q;
	logic [5:0]          divcnt_q;
	logic [15:0]         last_q;
	logic                done_q;
	rsp_t                rsp_q;

	logic                accept, is_query;
	logic                emit;
	rsp_t                emit_rsp;
	logic                anim_bad, frame_bad, last_idx;
	logic [TOTAL_W:0]    trial;
	logic                qbit;

	assign accept    = start && !busy;
	assign is_query  = accept && (req.func == FN_QUERY);
	assign busy      = (state_q != S_IDLE);
	assign done      = done_q;
	assign rsp       = rsp_q;
	assign cfg_ready = 1'b1;

	// Frame table: entries not yet written read as zero; animation entries are checked by valid flop.
	assign f_rd = fval_s1 ? frame_ent_t'(f_rdata) : '0;
	assign a_rd = anim_ent_t'(a_rdata);

	assign f_we    = accept && (req.func == FN_WR_FRAME);
	assign a_we    = accept && (req.func == FN_WR_ANIM)
		&& ({1'b0, req.entry_index} < 9'(ANIM_DEPTH));
	assign a_waddr = req.entry_index[ANIM_AW-1:0];
	assign f_wr    = '{sprite: req.sprite_num, duration: req.frame_time};
	assign a_wr    = '{first: req.first_frame, length: req.num_frames,
		repeats: req.loop_limit};
	assign a_raddr = req.anim_sel[ANIM_AW-1:0];

	afs_ram #(.WIDTH($bits(frame_ent_t)), .DEPTH(FRAME_DEPTH)) u_frame_ram (
		.clk   (clk),
		.we    (f_we),
		.waddr (req.entry_index[FRAME_AW-1:0]),
		.wdata (f_wr),
		.raddr (f_raddr),
		.rdata (f_rdata)
	);

	afs_ram #(.WIDTH($bits(anim_ent_t)), .DEPTH(ANIM_DEPTH)) u_anim_ram (
		.clk   (clk),
		.we    (a_we),
		.waddr (a_waddr),
		.wdata (a_wr),
		.raddr (a_raddr),
		.rdata (a_rdata)
	);

	assign anim_bad = id_bad_q || !aval_s1 || (a_rd.length == 9'd0)
		|| (({2'b0, a_rd.first} + {1'b0, a_rd.length}) > 10'(FRAME_DEPTH));
	assign frame_bad = (f_rd.duration == 32'd0) || (f_rd.sprite >= sprite_count_q);
	assign last_idx  = (idx_q == len_q - 9'd1);

	// Restoring divider step: one quotient bit per cycle.
	assign trial = {rem_q, quo_q[QUO_W-1]};
	assign qbit  = (trial >= {1'b0, total_q});

	always_comb begin
		state_d  = state_q;
		f_raddr  = ptr_q;
		emit     = 1'b0;
		emit_rsp = '{frame_sprite: 16'd0, finished: 1'b0, error: 1'b1};
		case (state_q)
			S_IDLE: begin
				if (is_query) begin
					state_d = S_ALOOK;
				end
			end
			S_ALOOK: begin
				f_raddr = a_rd.first;
				if (anim_bad) begin
					emit    = 1'b1;
					state_d = S_IDLE;
				end else begin
					state_d = S_SUM;
				end
			end
			S_SUM: begin
				if (frame_bad) begin
					emit    = 1'b1;
					state_d = S_IDLE;
				end else if (last_idx) begin
					state_d = S_DIV;
				end
			end
			S_DIV: begin
				if (divcnt_q == 6'd63) begin
					state_d = S_CHK;
				end
			end
			S_CHK: begin
				f_raddr = first_q;
				if ((rep_q != 32'd0) && (quo_q >= {32'd0, rep_q})) begin
					emit     = 1'b1;
					emit_rsp = '{frame_sprite: last_q, finished: 1'b1, error: 1'b0};
					state_d  = S_IDLE;
				end else begin
					state_d = S_WALK;
				end
			end
			S_WALK: begin
				if ((rem_q < {8'd0, f_rd.duration}) || last_idx) begin
					emit     = 1'b1;
					emit_rsp = '{frame_sprite: f_rd.sprite, finished: 1'b0, error: 1'b0};
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			sprite_count_q <= '0;
			anim_count_q   <= '0;
			fvalid_q       <= '0;
			avalid_q       <= '0;
			done_q         <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= emit;
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_SPRITE_COUNT: sprite_count_q <= cfg_data;
					CFG_ANIM_COUNT:   anim_count_q   <= cfg_data[6:0];
					default: ;
				endcase
			end
			if (f_we) begin
				fvalid_q[req.entry_index[FRAME_AW-1:0]] <= 1'b1;
			end
			if (a_we) begin
				avalid_q[a_waddr] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		fval_s1 <= fvalid_q[f_raddr];
		aval_s1 <= avalid_q[a_raddr];
		if (emit) begin
			rsp_q <= emit_rsp;
		end
		case (state_q)
			S_IDLE: begin
				id_bad_q <= ({1'b0, req.anim_sel} >= anim_count_q);
				quo_q    <= req.run_time;
			end
			S_ALOOK: begin
				first_q <= a_rd.first;
				len_q   <= a_rd.length;
				rep_q   <= a_rd.repeats;
				ptr_q   <= a_rd.first + 8'd1;
				idx_q   <= '0;
				total_q <= '0;
			end
			S_SUM: begin
				total_q <= total_q + {8'd0, f_rd.duration};
				ptr_q   <= ptr_q + 8'd1;
				idx_q   <= idx_q + 9'd1;
				last_q  <= f_rd.sprite;
				rem_q   <= '0;
				divcnt_q <= '0;
			end
			S_DIV: begin
				rem_q    <= qbit ? TOTAL_W'(trial - {1'b0, total_q}) : trial[TOTAL_W-1:0];
				quo_q    <= {quo_q[QUO_W-2:0], qbit};
				divcnt_q <= divcnt_q + 6'd1;
			end
			S_CHK: begin
				ptr_q <= first_q + 8'd1;
				idx_q <= '0;
			end
			S_WALK: begin
				rem_q <= rem_q - {8'd0, f_rd.duration};
				ptr_q <= ptr_q + 8'd1;
				idx_q <= idx_q + 9'd1;
			end
			default: ;
		endcase
	end

	`AFS_ASSERT(a_err_zero, !(done && rsp.error) || (rsp.frame_sprite == 16'd0 && !rsp.finished), "error result not cleared")
	`AFS_ASSERT_NEXT(a_done_single, done, !done, "back-to-back results")
	`AFS_ASSERT_NEXT(a_query_busy, is_query, busy, "query did not start")
	`AFS_ASSERT_NEXT(a_done_idle, emit, (state_q == S_IDLE) && done, "result without return to idle")
endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for animation_frame_select: frame/animation table
// writes and queries, checked against a behavioral predictor per request.
// ---------------------------------------------------------------------------
module tb;
	import afs_pkg::*;

	localparam int WATCHDOG_LIMIT = 20000;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	req_t        req;
	logic        done;
	rsp_t        rsp;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [7:0]  cfg_index;
	logic [15:0] cfg_data;

	// predictor state
	logic [15:0] sprite_limit;
	logic [6:0]  anim_limit;
	logic [15:0] frm_sprite [FRAME_DEPTH];
	logic [31:0] frm_time [FRAME_DEPTH];
	logic [7:0]  ani_first [ANIM_DEPTH];
	logic [8:0]  ani_len [ANIM_DEPTH];
	logic [31:0] ani_rep [ANIM_DEPTH];
	logic        ani_ok [ANIM_DEPTH];

	rsp_t pending_frames[$];
	int   fail_count;
	int   idle_cycles;

	animation_frame_select DUT (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .req(req),
		.done(done), .rsp(rsp), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		clk = 1'b0; #2;
		clk = 1'b1; #2;
	end

	function automatic rsp_t select_frame(logic [5:0] id, logic [63:0] elapsed);
		rsp_t r;
		logic [63:0] total, pos;
		int first, count;
		r = '{frame_sprite: 16'd0, finished: 1'b0, error: 1'b1};
		if ({1'b0, id} >= anim_limit)
			return r;
		first = ani_first[id];
		count = ani_len[id];
		if (!ani_ok[id] || count == 0 || first + count > FRAME_DEPTH)
			return r;
		total = 0;
		for (int i = 0; i < count; i++) begin
			if (frm_time[first + i] == 0 || frm_sprite[first + i] >= sprite_limit)
				return r;
			total += frm_time[first + i];
		end
		r.error = 1'b0;
		r.frame_sprite = frm_sprite[first + count - 1];
		if (ani_rep[id] != 0 && elapsed / total >= {32'd0, ani_rep[id]}) begin
			r.finished = 1'b1;
			return r;
		end
		pos = elapsed % total;
		for (int i = 0; i < count; i++) begin
			if (pos < {32'd0, frm_time[first + i]}) begin
				r.frame_sprite = frm_sprite[first + i];
				return r;
			end
			pos -= frm_time[first + i];
		end
		return r;
	endfunction

	// start stays high after an accept; the next task drops it or loads a new request
	task automatic send_request(req_t r, int gap);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		req   <= r;
		@(posedge clk);
		while (busy) @(posedge clk);
		case (r.func)
			FN_WR_FRAME: begin
				frm_sprite[r.entry_index] = r.sprite_num;
				frm_time[r.entry_index]   = r.frame_time;
			end
			FN_WR_ANIM: if (r.entry_index < ANIM_DEPTH) begin
				ani_first[r.entry_index[5:0]] = r.first_frame;
				ani_len[r.entry_index[5:0]]   = r.num_frames;
				ani_rep[r.entry_index[5:0]]   = r.loop_limit;
				ani_ok[r.entry_index[5:0]]    = 1'b1;
			end
			FN_QUERY: pending_frames.push_back(select_frame(r.anim_sel, r.run_time));
			default: ;
		endcase
	endtask

	task automatic drain_queries();
		start <= 1'b0;
		while (pending_frames.size() != 0) @(posedge clk);
		repeat (600) @(posedge clk);
	endtask

	// register writes only while no request is in flight
	task automatic write_register(logic [7:0] idx, logic [15:0] val);
		start <= 1'b0;
		while (busy || pending_frames.size() != 0) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		if (idx == CFG_SPRITE_COUNT) sprite_limit = val;
		else if (idx == CFG_ANIM_COUNT) anim_limit = val[6:0];
		@(posedge clk);
	endtask

	function automatic req_t blank_req(logic [1:0] fn);
		req_t r;
		logic [191:0] bits;
		bits = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
		r = bits[$bits(req_t)-1:0];
		r.func = fn;
		return r;
	endfunction

	task automatic put_frame(int idx, logic [15:0] spr, logic [31:0] dur, int gap);
		req_t r;
		r = blank_req(FN_WR_FRAME);
		r.entry_index = 8'(idx);
		r.sprite_num = spr;
		r.frame_time = dur;
		send_request(r, gap);
	endtask

	task automatic put_anim(int idx, int first, int count, logic [31:0] rep, int gap);
		req_t r;
		r = blank_req(FN_WR_ANIM);
		r.entry_index = 8'(idx);
		r.first_frame = 8'(first);
		r.num_frames = 9'(count);
		r.loop_limit = rep;
		send_request(r, gap);
	endtask

	task automatic ask(int id, logic [63:0] elapsed, int gap);
		req_t r;
		r = blank_req(FN_QUERY);
		r.anim_sel = 6'(id);
		r.run_time = elapsed;
		send_request(r, gap);
	endtask

	// directed: reset-state queries, bounds, errors, finish, extreme values
	task automatic test_directed();
		req_t r;
		ask(0, 64'd0, 0);
		write_register(CFG_SPRITE_COUNT, 16'hFFFF);
		write_register(CFG_ANIM_COUNT, 16'd64);
		ask(63, 64'hFFFF_FFFF_FFFF_FFFF, 0);
		put_frame(0, 16'd5, 32'd10, 0);
		put_frame(1, 16'hFFFE, 32'hFFFF_FFFF, 0);
		put_frame(255, 16'd7, 32'd1, 0);
		put_frame(254, 16'hFFFF, 32'd3, 0);
		put_anim(0, 0, 2, 32'd0, 0);
		put_anim(1, 0, 2, 32'd1, 0);
		put_anim(2, 255, 1, 32'hFFFF_FFFF, 0);
		put_anim(3, 255, 2, 32'd0, 0);
		put_anim(4, 2, 0, 32'd0, 0);
		put_anim(5, 254, 2, 32'd0, 0);
		put_anim(63, 0, 256, 32'd2, 0);
		put_anim(200, 0, 1, 32'd1, 0);
		r = blank_req(2'd3);
		send_request(r, 0);
		ask(0, 64'd9, 0);
		ask(0, 64'd10, 0);
		ask(1, 64'hFFFF_FFFF_FFFF_FFFF, 0);
		ask(2, 64'hFFFF_FFFF_FFFF_FFFF, 0);
		ask(3, 64'd0, 0);
		ask(4, 64'd0, 0);
		ask(5, 64'd1, 0);
		ask(63, 64'd5, 0);
		ask(6, 64'd5, 0);
		drain_queries();
	endtask

	// random: small animations over a frame pool, mostly valid queries
	task automatic test_random(int n);
		for (int k = 0; k < n; k++) begin
			int sel, gap;
			sel = $urandom_range(0, 99);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
			if (sel < 25)
				put_frame($urandom_range(0, 40) == 0 ? $urandom_range(0, 255) :
					$urandom_range(0, 31),
					$urandom_range(0, 9) == 0 ? 16'($urandom) : 16'($urandom_range(0, 300)),
					$urandom_range(0, 19) == 0 ? $urandom :
						($urandom_range(0, 19) == 0 ? 32'd0 : $urandom_range(1, 1000)), gap);
			else if (sel < 40)
				put_anim($urandom_range(0, 9) == 0 ? $urandom_range(0, 255) :
					$urandom_range(0, 15),
					$urandom_range(0, 9) == 0 ? $urandom_range(0, 255) : $urandom_range(0, 28),
					$urandom_range(0, 19) == 0 ? $urandom_range(0, 511) : $urandom_range(1, 4),
					$urandom_range(0, 2) == 0 ? 32'd0 :
						($urandom_range(0, 9) == 0 ? $urandom : $urandom_range(1, 5)), gap);
			else if (sel < 98)
				ask($urandom_range(0, 9) == 0 ? $urandom_range(0, 63) : $urandom_range(0, 15),
					$urandom_range(0, 4) == 0 ? {$urandom, $urandom} :
						64'($urandom_range(0, 20000)), gap);
			else begin
				req_t r;
				r = blank_req(2'd3);
				send_request(r, gap);
			end
		end
		drain_queries();
	endtask

	task automatic test_registers();
		write_register(CFG_SPRITE_COUNT, 16'd0);
		write_register(CFG_ANIM_COUNT, 16'd0);
		test_random(60);
		write_register(CFG_SPRITE_COUNT, 16'd200);
		write_register(CFG_ANIM_COUNT, 16'd10);
		test_random(250);
		write_register(CFG_SPRITE_COUNT, 16'hFFFF);
		write_register(CFG_ANIM_COUNT, 16'd127);
		test_random(560);
	endtask

	// results are checked in order at the edge closing the strobe cycle
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (pending_frames.size() == 0) begin
				$display("%0t unexpected result: actual %h", $time, rsp);
				fail_count++;
			end else begin
				rsp_t exp_r;
				exp_r = pending_frames.pop_front();
				if (rsp.frame_sprite !== exp_r.frame_sprite || rsp.finished !== exp_r.finished
						|| rsp.error !== exp_r.error) begin
					$display("%0t mismatch: expected sprite %h fin %b err %b, actual %h %b %b",
						$time, exp_r.frame_sprite, exp_r.finished, exp_r.error,
						rsp.frame_sprite, rsp.finished, rsp.error);
					fail_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((start && !busy) || done || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		req = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		fail_count = 0;
		idle_cycles = 0;
		sprite_limit = 0;
		anim_limit = 0;
		for (int i = 0; i < FRAME_DEPTH; i++) begin
			frm_sprite[i] = 0;
			frm_time[i] = 0;
		end
		for (int i = 0; i < ANIM_DEPTH; i++) begin
			ani_first[i] = 0;
			ani_len[i] = 0;
			ani_rep[i] = 0;
			ani_ok[i] = 1'b0;
		end
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_registers();
		if (pending_frames.size() != 0)
			fail_count++;
		if (fail_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end
endmodule
